/* src/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the segment line fitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked every clock outside reset.
`define SSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SSL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ssl_pkg.sv */
// Types, constants and helper functions of the segment line fitter.
`timescale 1ns / 1ps
package ssl_pkg;

  localparam int MAX_SEG_POINTS = 2048;
  localparam int COORD_BITS     = 10;
  localparam int CNT_W          = 12;
  localparam int SUM_W          = 21;
  localparam int SQ_W           = 31;
  localparam int DIST_W         = 16;
  localparam int OBJ_W          = 8;
  localparam int Q_W            = 32;
  localparam int WIDE_W         = 42;
  localparam int LIM_W          = 38;
  localparam int MUL_W          = 44;
  localparam int MUL_DIG        = 11;
  localparam int MUL_STEPS      = 4;
  localparam int PROD_W         = 88;
  localparam int DIV_NUM_W      = 64;
  localparam int DIV_DEN_W      = 43;

  // Snapshot of a closed segment handed to the fit sequencer.
  typedef struct packed {
    logic                  ok;
    logic                  gt_min;
    logic [OBJ_W-1:0]      id;
    logic [CNT_W-1:0]      n;
    logic [SUM_W-1:0]      sx;
    logic [SUM_W-1:0]      sy;
    logic [SQ_W-1:0]       sxx;
    logic [SQ_W-1:0]       sxy;
    logic [SQ_W-1:0]       syy;
    logic [COORD_BITS-1:0] xlo;
    logic [COORD_BITS-1:0] xhi;
    logic [COORD_BITS-1:0] ylo;
    logic [COORD_BITS-1:0] yhi;
  } seg_t;

  // Finished segment record.
  typedef struct packed {
    logic                  ok;
    logic [OBJ_W-1:0]      id;
    logic [CNT_W-1:0]      n;
    logic [Q_W-1:0]        slope;
    logic [Q_W-1:0]        intercept;
    logic [Q_W-1:0]        ya;
    logic [Q_W-1:0]        yb;
    logic [COORD_BITS-1:0] xlo;
    logic [COORD_BITS-1:0] xhi;
    logic [COORD_BITS-1:0] ylo;
    logic [COORD_BITS-1:0] yhi;
    logic                  good;
  } res_t;

  // Signed Q16.16 from a magnitude; sat marks a magnitude of 2^31 or more.
  function automatic logic [Q_W-1:0] sat_mag(input logic neg, input logic sat,
                                             input logic [Q_W-1:0] q);
    logic [Q_W-1:0] r;
    if (neg) r = sat ? {1'b1, {(Q_W-1){1'b0}}} : (~q + 1'b1);
    else     r = sat ? {1'b0, {(Q_W-1){1'b1}}} : q;
    return r;
  endfunction

  // sat32(+/-mag + b)
  function automatic logic [Q_W-1:0] sat_sum(input logic neg, input logic [WIDE_W-1:0] mag,
                                             input logic [Q_W-1:0] b);
    logic [WIDE_W+1:0] p;
    logic [WIDE_W+1:0] s;
    p = {2'b00, mag};
    if (neg) p = ~p + 1'b1;
    s = p + {{(WIDE_W+2-Q_W){b[Q_W-1]}}, b};
    if (s[WIDE_W+1:Q_W-1] != {(WIDE_W+3-Q_W){s[WIDE_W+1]}})
      return s[WIDE_W+1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    return s[Q_W-1:0];
  endfunction

endpackage

/* src/ssl_mul.sv */
// Shared multiplier: 44 x 44 bits, one 11-bit digit of b per cycle.
`timescale 1ns / 1ps
module ssl_mul import ssl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output logic              busy_o,
  output logic [PROD_W-1:0] prod_o
);

  logic [MUL_W-1:0]         a_q;
  logic [MUL_W-1:0]         b_q;
  logic [PROD_W-1:0]        acc_q;
  logic [2:0]               cnt_q, cnt_d;
  logic [MUL_W+MUL_DIG-1:0] partial;

  // partial product of a and the top digit of b
  assign partial = a_q * b_q[MUL_W-1 -: MUL_DIG];
  assign busy_o  = (cnt_q != 3'd0);
  assign prod_o  = acc_q;

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) cnt_d = 3'(MUL_STEPS);
    else if (busy_o) cnt_d = cnt_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 3'd0;
    else cnt_q <= cnt_d;
  end

  // shift-and-add, most significant digit first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_o) begin
      b_q   <= {b_q[MUL_W-MUL_DIG-1:0], {MUL_DIG{1'b0}}};
      acc_q <= {acc_q[PROD_W-MUL_DIG-1:0], {MUL_DIG{1'b0}}} + PROD_W'(partial);
    end
  end

endmodule

/* src/ssl_div.sv */
// Shared restoring divider: 32 quotient bits, one per cycle, with overflow flag.
`timescale 1ns / 1ps
module ssl_div import ssl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 busy_o,
  output logic [Q_W-1:0]       q_o,
  output logic                 ovf_o
);

  logic [DIV_DEN_W:0]   rem_q;
  logic [Q_W-1:0]       low_q;
  logic [Q_W-1:0]       q_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic                 ovf_q;
  logic [5:0]           cnt_q, cnt_d;
  logic [DIV_DEN_W:0]   shifted;
  logic                 fit;

  assign shifted = {rem_q[DIV_DEN_W-1:0], low_q[Q_W-1]};
  assign fit     = (shifted >= {1'b0, den_q});
  assign busy_o  = (cnt_q != 6'd0);
  assign q_o     = q_q;
  assign ovf_o   = ovf_q;

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) cnt_d = 6'(Q_W);
    else if (busy_o) cnt_d = cnt_q - 6'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 6'd0;
    else cnt_q <= cnt_d;
  end

  // quotient of 2^32 or more is flagged up front, then 32 subtract steps
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q <= ({{(DIV_DEN_W-Q_W){1'b0}}, num_i[DIV_NUM_W-1:Q_W]} >= den_i);
      rem_q <= {{(DIV_DEN_W+1-Q_W){1'b0}}, num_i[DIV_NUM_W-1:Q_W]};
      low_q <= num_i[Q_W-1:0];
      den_q <= den_i;
      q_q   <= '0;
    end else if (busy_o) begin
      rem_q <= fit ? (shifted - {1'b0, den_q}) : shifted;
      low_q <= {low_q[Q_W-2:0], 1'b0};
      q_q   <= {q_q[Q_W-2:0], fit};
    end
  end

endmodule

/* src/ssl_fit.sv */
// Fit sequencer: least-squares line of a closed segment on the shared units.
`timescale 1ns / 1ps
module ssl_fit import ssl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  seg_t        seg_i,
  input  logic [15:0] fit_limit_i,
  output logic        idle_o,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_MUL_GO   = 6'b000010,
    S_MUL_WAIT = 6'b000100,
    S_DIV_GO   = 6'b001000,
    S_DIV_WAIT = 6'b010000,
    S_DONE     = 6'b100000
  } fit_state_e;

  // product program
  typedef enum logic [3:0] {
    ST_N_SXX   = 4'd0,
    ST_SX_SX   = 4'd1,
    ST_N_SYY   = 4'd2,
    ST_SY_SY   = 4'd3,
    ST_N_SXY   = 4'd4,
    ST_SX_SY   = 4'd5,
    ST_N_N     = 4'd6,
    ST_LIM     = 4'd7,
    ST_AM_SX   = 4'd8,
    ST_AM_XLO  = 4'd9,
    ST_AM_XHI  = 4'd10,
    ST_E_DD    = 4'd11,
    ST_NM_NM   = 4'd12,
    ST_LIM_DD  = 4'd13
  } step_e;

  fit_state_e state_q, state_d;
  step_e      step_q, step_d;
  logic       div_sel_q, div_sel_d;

  seg_t              seg_q;
  logic [WIDE_W-1:0] t_q, dd_q, e_q, nmag_q;
  logic              nneg_q;
  logic [LIM_W-1:0]  lim_q;
  logic [Q_W-1:0]    a_q, am_q, b_q, ya_q, yb_q;
  logic [53:0]       bm_q;
  logic              bneg_q;
  logic [83:0]       lhs_q, r1_q;
  logic              good_q;

  logic              mul_start, mul_busy, div_start, div_busy, div_ovf;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    div_q, div_val;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [WIDE_W-1:0] p42;
  logic [36:0]       bp;
  logic [52:0]       bq;
  logic [84:0]       rsum;
  logic              mul_done, div_done, div_sat;

  assign mul_start = (state_q == S_MUL_GO);
  assign div_start = (state_q == S_DIV_GO);
  assign mul_done  = (state_q == S_MUL_WAIT) && !mul_busy;
  assign div_done  = (state_q == S_DIV_WAIT) && !div_busy;
  assign p42       = prod[WIDE_W-1:0];
  assign bp        = {seg_q.sy, 16'd0};
  assign bq        = prod[52:0];
  assign rsum      = {1'b0, r1_q} + {1'b0, prod[83:0]};
  assign div_sat   = div_ovf | div_q[Q_W-1];
  assign div_val   = sat_mag(div_sel_q ? bneg_q : nneg_q, div_sat, div_q);

  // operand select for the shared multiplier
  always_comb begin
    unique case (step_q)
      ST_N_SXX:  begin mul_a = MUL_W'(seg_q.n);  mul_b = MUL_W'(seg_q.sxx); end
      ST_SX_SX:  begin mul_a = MUL_W'(seg_q.sx); mul_b = MUL_W'(seg_q.sx);  end
      ST_N_SYY:  begin mul_a = MUL_W'(seg_q.n);  mul_b = MUL_W'(seg_q.syy); end
      ST_SY_SY:  begin mul_a = MUL_W'(seg_q.sy); mul_b = MUL_W'(seg_q.sy);  end
      ST_N_SXY:  begin mul_a = MUL_W'(seg_q.n);  mul_b = MUL_W'(seg_q.sxy); end
      ST_SX_SY:  begin mul_a = MUL_W'(seg_q.sx); mul_b = MUL_W'(seg_q.sy);  end
      ST_N_N:    begin mul_a = MUL_W'(seg_q.n);  mul_b = MUL_W'(seg_q.n);   end
      ST_LIM:    begin mul_a = MUL_W'(t_q);      mul_b = MUL_W'(fit_limit_i); end
      ST_AM_SX:  begin mul_a = MUL_W'(am_q);     mul_b = MUL_W'(seg_q.sx);  end
      ST_AM_XLO: begin mul_a = MUL_W'(am_q);     mul_b = MUL_W'(seg_q.xlo); end
      ST_AM_XHI: begin mul_a = MUL_W'(am_q);     mul_b = MUL_W'(seg_q.xhi); end
      ST_E_DD:   begin mul_a = MUL_W'(e_q);      mul_b = MUL_W'(dd_q);      end
      ST_NM_NM:  begin mul_a = MUL_W'(nmag_q);   mul_b = MUL_W'(nmag_q);    end
      ST_LIM_DD: begin mul_a = MUL_W'(lim_q);    mul_b = MUL_W'(dd_q);      end
      default:   begin mul_a = '0;               mul_b = '0;                end
    endcase
  end

  // divider: slope = |num| << 16 / dd, then intercept = bm / n
  always_comb begin
    if (div_sel_q) begin
      div_num = DIV_NUM_W'(bm_q);
      div_den = DIV_DEN_W'(seg_q.n);
    end else begin
      div_num = DIV_NUM_W'({nmag_q, 16'd0});
      div_den = DIV_DEN_W'(dd_q);
    end
  end

  ssl_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (prod)
  );

  ssl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .q_o     (div_q),
    .ovf_o   (div_ovf)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    div_sel_d = div_sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = seg_i.ok ? S_MUL_GO : S_DONE;
          step_d  = ST_N_SXX;
        end
      end
      S_MUL_GO: state_d = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (!mul_busy) begin
          unique case (step_q)
            ST_LIM: begin
              if (dd_q != '0) begin
                state_d   = S_DIV_GO;
                div_sel_d = 1'b0;
              end else begin
                state_d = S_MUL_GO;
                step_d  = ST_AM_SX;
              end
            end
            ST_AM_SX: begin
              state_d   = S_DIV_GO;
              div_sel_d = 1'b1;
            end
            ST_LIM_DD: state_d = S_DONE;
            default: begin
              state_d = S_MUL_GO;
              step_d  = step_e'(step_q + 4'd1);
            end
          endcase
        end
      end
      S_DIV_GO: state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (!div_busy) begin
          state_d = S_MUL_GO;
          step_d  = div_sel_q ? ST_AM_XLO : ST_AM_SX;
        end
      end
      S_DONE: if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= ST_N_SXX;
      div_sel_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      div_sel_q <= div_sel_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      seg_q  <= seg_i;
      a_q    <= '0;
      am_q   <= '0;
      b_q    <= '0;
      ya_q   <= '0;
      yb_q   <= '0;
      good_q <= 1'b0;
    end
    if (div_done) begin
      if (div_sel_q) begin
        b_q <= div_val;
      end else begin
        a_q  <= div_val;
        am_q <= div_val[Q_W-1] ? (~div_val + 1'b1) : div_val;
      end
    end
    if (mul_done) begin
      unique case (step_q)
        ST_N_SXX, ST_N_SYY, ST_N_SXY, ST_N_N: t_q <= p42;
        ST_SX_SX: dd_q <= t_q - p42;
        ST_SY_SY: e_q  <= t_q - p42;
        ST_SX_SY: begin
          nneg_q <= (t_q < p42);
          nmag_q <= (t_q < p42) ? (p42 - t_q) : (t_q - p42);
        end
        ST_LIM: lim_q <= prod[LIM_W-1:0];
        ST_AM_SX: begin
          if (a_q[Q_W-1]) begin
            bm_q   <= {17'd0, bp} + {1'b0, bq};
            bneg_q <= 1'b0;
          end else begin
            bneg_q <= (bq > {16'd0, bp});
            bm_q   <= (bq > {16'd0, bp}) ? {1'b0, bq - {16'd0, bp}}
                                         : {1'b0, {16'd0, bp} - bq};
          end
        end
        ST_AM_XLO: ya_q <= sat_sum(a_q[Q_W-1], p42, b_q);
        ST_AM_XHI: yb_q <= sat_sum(a_q[Q_W-1], p42, b_q);
        ST_E_DD:   lhs_q <= prod[83:0];
        ST_NM_NM:  r1_q  <= prod[83:0];
        ST_LIM_DD: begin
          if (dd_q == '0) good_q <= seg_q.gt_min && (e_q <= WIDE_W'(lim_q));
          else good_q <= seg_q.gt_min && ({1'b0, lhs_q} <= rsum);
        end
        default: ;
      endcase
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.ok        = seg_q.ok;
    res_o.id        = seg_q.id;
    res_o.n         = seg_q.n;
    res_o.slope     = a_q;
    res_o.intercept = b_q;
    res_o.ya        = ya_q;
    res_o.yb        = yb_q;
    res_o.xlo       = seg_q.xlo;
    res_o.xhi       = seg_q.xhi;
    res_o.ylo       = seg_q.ylo;
    res_o.yhi       = seg_q.yhi;
    res_o.good      = good_q;
  end

endmodule

/* src/scan_segment_line_fit.sv */
// Top level: scan segmentation, per-segment accumulation, config and output register.
//
// Usage: scan points enter on the s_axis channel (x, y, range in tdata, scan end on
// tlast). Every point that closes a segment (range jump above max_dist_jump, full
// segment or last point of a scan) yields one segment record on m_axis; segment_ok
// rides on tuser. Registers max_dist_jump, min_points, fit_limit sit on the APB port
// at byte addresses 0, 4 and 8; write them only while the block is idle.
// Flow: a point that closes nothing leaves the fit sequencer idle, so the next point
// can be taken in the following cycle. A point that closes a rejected segment sends
// the sequencer straight to its done state until the output register takes the record.
// A point that closes an accepted segment starts the fit sequencer: 14 products on the
// shared multiplier and two 32-step divisions (one when every x of the segment is
// equal, as the slope division is then skipped), then the record is handed over;
// s_axis_tready stays low meanwhile.
// A finished record enters the output register when that register is free. The output
// register holds a record while the receiver stalls; the next points are still taken
// until another record is ready, which then waits in the sequencer.
// Reset: registers return to 100, 10, 17, the segment and object count clear and
// the next point starts a new scan.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scan_segment_line_fit import ssl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // point stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // x_coord[9:0], y_coord[19:10], distance[35:20], zero
  input  logic         s_axis_tlast,  // last_point
  // segment records
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // obj_id[7:0], point_count[19:8], slope[51:20], intercept[83:52], y_at_min_x[115:84],
  // y_at_max_x[147:116], min_x[157:148], max_x[167:158], min_y[177:168],
  // max_y[187:178], good_fit[188], zero
  output logic [191:0] m_axis_tdata,
  output logic         m_axis_tuser   // segment_ok
);

  typedef enum logic [1:0] {
    REG_MAX_JUMP   = 2'd0,
    REG_MIN_POINTS = 2'd1,
    REG_FIT_LIMIT  = 2'd2
  } reg_e;

  logic [15:0] max_jump_q, fit_lim_q;
  logic [11:0] min_pts_q;
  logic        cfg_wr;
  reg_e        cfg_idx;

  logic [CNT_W-1:0]      cnt_q, cur_cnt, base_cnt;
  logic [SUM_W-1:0]      sx_q, sy_q, cur_sx, cur_sy, base_sx, base_sy;
  logic [SQ_W-1:0]       sxx_q, sxy_q, syy_q, cur_sxx, cur_sxy, cur_syy;
  logic [SQ_W-1:0]       base_sxx, base_sxy, base_syy;
  logic [COORD_BITS-1:0] xlo_q, xhi_q, ylo_q, yhi_q, cur_xlo, cur_xhi, cur_ylo, cur_yhi;
  logic [COORD_BITS-1:0] base_xlo, base_xhi, base_ylo, base_yhi;
  logic [DIST_W-1:0]     prev_q, diff;
  logic [OBJ_W-1:0]      obj_q, cur_obj;
  logic                  scan_start_q;

  logic [COORD_BITS-1:0] in_x, in_y;
  logic [DIST_W-1:0]     in_d;
  logic [19:0]           p_xx, p_xy, p_yy;
  logic                  accept, close, seg_ok;
  seg_t                  seg;

  logic  fit_idle, fit_res_valid, out_ready, out_load;
  res_t  fit_res, out_q;
  logic  m_valid_q, m_valid_d;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_MAX_JUMP:   prdata = {16'd0, max_jump_q};
      REG_MIN_POINTS: prdata = {20'd0, min_pts_q};
      REG_FIT_LIMIT:  prdata = {16'd0, fit_lim_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_jump_q <= 16'd100;
      min_pts_q  <= 12'd10;
      fit_lim_q  <= 16'd17;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MAX_JUMP:   max_jump_q <= pwdata[15:0];
        REG_MIN_POINTS: min_pts_q  <= pwdata[11:0];
        REG_FIT_LIMIT:  fit_lim_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // input fields
  assign in_x          = s_axis_tdata[9:0];
  assign in_y          = s_axis_tdata[19:10];
  assign in_d          = s_axis_tdata[35:20];
  assign s_axis_tready = fit_idle;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // segment as seen by this point: empty at scan start
  always_comb begin
    cur_cnt = scan_start_q ? '0 : cnt_q;
    cur_sx  = scan_start_q ? '0 : sx_q;
    cur_sy  = scan_start_q ? '0 : sy_q;
    cur_sxx = scan_start_q ? '0 : sxx_q;
    cur_sxy = scan_start_q ? '0 : sxy_q;
    cur_syy = scan_start_q ? '0 : syy_q;
    cur_xlo = scan_start_q ? '0 : xlo_q;
    cur_xhi = scan_start_q ? '0 : xhi_q;
    cur_ylo = scan_start_q ? '0 : ylo_q;
    cur_yhi = scan_start_q ? '0 : yhi_q;
    cur_obj = scan_start_q ? '0 : obj_q;
  end

  // close test
  assign diff   = (in_d > prev_q) ? (in_d - prev_q) : (prev_q - in_d);
  assign close  = scan_start_q ? s_axis_tlast
                               : ((diff > max_jump_q) ||
                                  (cur_cnt >= CNT_W'(MAX_SEG_POINTS)) || s_axis_tlast);
  assign seg_ok = (cur_cnt != '0) && (cur_cnt >= min_pts_q);

  always_comb begin
    seg.ok     = seg_ok;
    seg.gt_min = (cur_cnt > min_pts_q);
    seg.id     = seg_ok ? cur_obj : '0;
    seg.n      = cur_cnt;
    seg.sx     = cur_sx;
    seg.sy     = cur_sy;
    seg.sxx    = cur_sxx;
    seg.sxy    = cur_sxy;
    seg.syy    = cur_syy;
    seg.xlo    = cur_xlo;
    seg.xhi    = cur_xhi;
    seg.ylo    = cur_ylo;
    seg.yhi    = cur_yhi;
  end

  // the closing point opens the next segment
  always_comb begin
    base_cnt = close ? '0 : cur_cnt;
    base_sx  = close ? '0 : cur_sx;
    base_sy  = close ? '0 : cur_sy;
    base_sxx = close ? '0 : cur_sxx;
    base_sxy = close ? '0 : cur_sxy;
    base_syy = close ? '0 : cur_syy;
    base_xlo = close ? '0 : cur_xlo;
    base_xhi = close ? '0 : cur_xhi;
    base_ylo = close ? '0 : cur_ylo;
    base_yhi = close ? '0 : cur_yhi;
  end

  assign p_xx = in_x * in_x;
  assign p_xy = in_x * in_y;
  assign p_yy = in_y * in_y;

  // accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      sx_q         <= '0;
      sy_q         <= '0;
      sxx_q        <= '0;
      sxy_q        <= '0;
      syy_q        <= '0;
      xlo_q        <= '0;
      xhi_q        <= '0;
      ylo_q        <= '0;
      yhi_q        <= '0;
      prev_q       <= '0;
      obj_q        <= '0;
      scan_start_q <= 1'b1;
    end else if (accept) begin
      cnt_q  <= base_cnt + 1'b1;
      sx_q   <= base_sx + SUM_W'(in_x);
      sy_q   <= base_sy + SUM_W'(in_y);
      sxx_q  <= base_sxx + SQ_W'(p_xx);
      sxy_q  <= base_sxy + SQ_W'(p_xy);
      syy_q  <= base_syy + SQ_W'(p_yy);
      if (base_cnt == '0) begin
        xlo_q <= in_x;
        xhi_q <= in_x;
        ylo_q <= in_y;
        yhi_q <= in_y;
      end else begin
        xlo_q <= (in_x < base_xlo) ? in_x : base_xlo;
        xhi_q <= (in_x > base_xhi) ? in_x : base_xhi;
        ylo_q <= (in_y < base_ylo) ? in_y : base_ylo;
        yhi_q <= (in_y > base_yhi) ? in_y : base_yhi;
      end
      prev_q       <= in_d;
      obj_q        <= (close && seg_ok) ? cur_obj + 1'b1 : cur_obj;
      scan_start_q <= s_axis_tlast;
    end
  end

  ssl_fit u_fit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && close),
    .seg_i       (seg),
    .fit_limit_i (fit_lim_q),
    .idle_o      (fit_idle),
    .res_valid_o (fit_res_valid),
    .res_ready_i (out_ready),
    .res_o       (fit_res)
  );

  // output register
  assign out_ready = !m_valid_q || m_axis_tready;
  assign out_load  = fit_res_valid && out_ready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else m_valid_q <= m_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= fit_res;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_q.ok;
  assign m_axis_tdata  = {3'b000, out_q.good, out_q.yhi, out_q.ylo, out_q.xhi, out_q.xlo,
                          out_q.yb, out_q.ya, out_q.intercept, out_q.slope,
                          out_q.n, out_q.id};

  // checks
  `SSL_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAX_SEG_POINTS + 1), "segment count overrun")
  `SSL_ASSERT_NEXT(a_load_shows, out_load, m_axis_tvalid, "fit record not shown")
  `SSL_ASSERT_IMP(a_reject_zero, m_axis_tvalid && !m_axis_tuser,
                  (m_axis_tdata[51:20] == 32'd0) && !m_axis_tdata[188],
                  "rejected record carries a fit")

endmodule
